// File: hw/rtl/chs_pkg.sv
package chs_pkg;

    localparam int MAX_BUCKETS = 256;
    localparam int POOL_NODES  = 1024;
    localparam int KEY_BITS    = 32;

    localparam int BKT_W  = $clog2(MAX_BUCKETS);     // bucket index
    localparam int CNT_W  = 9;                       // bucket_count register
    localparam int NODE_W = $clog2(POOL_NODES);      // node index
    localparam int LINK_W = NODE_W + 1;              // node index or empty marker

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_NODES);

    typedef enum logic [1:0] {
        K_LOOKUP = 2'd0,
        K_INSERT = 2'd1,
        K_REMOVE = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_HREAD,
        S_HWAIT,
        S_NODE,
        S_MISS,
        S_HIT,
        S_ALLOC,
        S_FREE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]          kind;
        logic [KEY_BITS-1:0] key;
    } t_in_word;

    typedef struct packed {
        logic ok;
        logic pool_full;
    } t_out_word;

endpackage

// File: hw/rtl/chs_mod.sv
// Key modulo bucket count, restoring remainder, one key bit per cycle.
module chs_mod
    import chs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [CNT_W-1:0]    i_div,
    output logic                o_done,
    output logic [BKT_W-1:0]    o_rem
);

    localparam int STEP_W = $clog2(KEY_BITS + 1);

    logic [KEY_BITS-1:0] r_q,    n_q;
    logic [CNT_W-1:0]    r_rem,  n_rem;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_W:0]      shifted;

    // one remainder step
    always_comb begin
        shifted = {r_rem, r_q[KEY_BITS-1]};
        n_q     = r_q;
        n_rem   = r_rem;
        n_step  = r_step;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_q    = i_key;
            n_rem  = '0;
            n_step = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (shifted >= {1'b0, i_div}) begin
                shifted = shifted - {1'b0, i_div};
            end
            n_rem  = shifted[CNT_W-1:0];
            n_q    = {r_q[KEY_BITS-2:0], 1'b0};
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(KEY_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_step <= n_step;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[BKT_W-1:0];

endmodule

// File: hw/rtl/chained_hash_set.sv
// Hash set of 32-bit keys, separate chaining over a pool of 1024 nodes and up
// to 256 buckets. One item at a time: the bit-serial modulo unit yields the
// bucket index, then the bucket head is read and the chain is walked one node
// per node memory read, then come the allocation or unlink writes, and last the
// result is posted. Bucket heads clear at once on reset; node memory is not
// initialized. Results wait in an output register, so the next word can be
// taken while the previous result is stalled.
module chained_hash_set
    import chs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_bcount;
    logic [CNT_W-1:0]    div_eff;
    logic [1:0]          r_kind;
    logic [KEY_BITS-1:0] r_key;
    logic [BKT_W-1:0]    r_bucket;
    logic [LINK_W-1:0]   r_head, r_cur, r_prev, r_next, r_free, r_hw;
    logic [NODE_W-1:0]   r_steps;
    logic                r_ok, r_full;
    logic                r_out_valid;
    t_out_word           r_out;
    logic                mod_start;
    logic                mod_done;
    logic [BKT_W-1:0]    mod_rem;

    // memories
    logic [LINK_W-1:0]   head_mem [MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0] r_head_v;
    logic [LINK_W-1:0]   r_head_q;
    logic                r_head_vq;
    logic [KEY_BITS-1:0] key_mem  [POOL_NODES];
    logic [LINK_W-1:0]   link_mem [POOL_NODES];
    logic [KEY_BITS-1:0] r_key_q;
    logic [LINK_W-1:0]   r_link_q;

    logic                head_we;
    logic [LINK_W-1:0]   head_wd;
    logic                key_we;
    logic                link_we;
    logic [NODE_W-1:0]   link_wa;
    logic [LINK_W-1:0]   link_wd;
    logic [NODE_W-1:0]   node_ra;
    logic [LINK_W-1:0]   head_cur;
    logic                accept, out_load;

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign head_cur    = r_head_vq ? r_head_q : NIL_LINK;

    // bucket count clamp
    always_comb begin
        priority if (r_bcount == '0) begin
            div_eff = CNT_W'(1);
        end else if (r_bcount > CNT_W'(MAX_BUCKETS)) begin
            div_eff = CNT_W'(MAX_BUCKETS);
        end else begin
            div_eff = r_bcount;
        end
    end

    assign mod_start = accept && (t_kind'(i_in_data.kind) != K_NONE);

    chs_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_key   (i_in_data.key),
        .i_div   (div_eff),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = mod_start ? S_MOD : S_DONE;
                end
            end
            S_MOD:   if (mod_done) n_state = S_HREAD;
            S_HREAD: n_state = S_HWAIT;
            S_HWAIT: n_state = (head_cur == NIL_LINK) ? S_MISS : S_NODE;
            S_NODE: begin
                if (r_key_q == r_key) begin
                    n_state = S_HIT;
                end else if (r_link_q >= NIL_LINK || r_steps == NODE_W'(POOL_NODES - 1)) begin
                    n_state = S_MISS;
                end
            end
            S_MISS: begin
                if (t_kind'(r_kind) == K_INSERT && r_free != NIL_LINK) begin
                    n_state = S_ALLOC;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_HIT:   n_state = (t_kind'(r_kind) == K_REMOVE) ? S_FREE : S_DONE;
            S_ALLOC: n_state = S_DONE;
            S_FREE:  n_state = S_DONE;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory ports
    always_comb begin
        head_we = 1'b0;
        head_wd = r_next;
        key_we  = 1'b0;
        link_we = 1'b0;
        link_wa = r_cur[NODE_W-1:0];
        link_wd = r_free;
        node_ra = r_cur[NODE_W-1:0];
        unique case (r_state)
            S_HWAIT: node_ra = head_cur[NODE_W-1:0];
            S_NODE:  node_ra = r_link_q[NODE_W-1:0];
            S_MISS: begin
                node_ra = r_free[NODE_W-1:0];
                if (t_kind'(r_kind) == K_INSERT && r_free == NIL_LINK && r_hw < NIL_LINK) begin
                    // fresh node from the never-used range
                    head_we = 1'b1;
                    head_wd = r_hw;
                    key_we  = 1'b1;
                    link_we = 1'b1;
                    link_wa = r_hw[NODE_W-1:0];
                    link_wd = r_head;
                end
            end
            S_ALLOC: begin
                head_we = 1'b1;
                head_wd = r_free;
                key_we  = 1'b1;
                link_we = 1'b1;
                link_wa = r_free[NODE_W-1:0];
                link_wd = r_head;
            end
            S_HIT: begin
                // unlink
                if (t_kind'(r_kind) == K_REMOVE) begin
                    if (r_prev == NIL_LINK) begin
                        head_we = 1'b1;
                        head_wd = r_next;
                    end else begin
                        link_we = 1'b1;
                        link_wa = r_prev[NODE_W-1:0];
                        link_wd = r_next;
                    end
                end
            end
            S_FREE: begin
                link_we = 1'b1;
                link_wa = r_cur[NODE_W-1:0];
                link_wd = r_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            head_mem[r_bucket] <= head_wd;
        end
        r_head_q <= head_mem[r_bucket];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[link_wa] <= r_key;
        end
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        r_key_q  <= key_mem[node_ra];
        r_link_q <= link_mem[node_ra];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_in_data.kind;
            r_key  <= i_in_data.key;
            r_ok   <= 1'b0;
            r_full <= 1'b0;
        end
        if (mod_done) begin
            r_bucket <= mod_rem;
        end
        if (r_state == S_HREAD) begin
            r_head_vq <= r_head_v[r_bucket];
        end
        unique case (r_state)
            S_HWAIT: begin
                r_head  <= head_cur;
                r_cur   <= head_cur;
                r_prev  <= NIL_LINK;
                r_steps <= '0;
            end
            S_NODE: begin
                if (r_key_q == r_key) begin
                    r_next <= r_link_q;
                end else begin
                    r_prev  <= r_cur;
                    r_cur   <= r_link_q;
                    r_steps <= r_steps + 1'b1;
                end
            end
            S_MISS: begin
                if (t_kind'(r_kind) == K_INSERT && r_free == NIL_LINK) begin
                    r_ok   <= (r_hw < NIL_LINK);
                    r_full <= !(r_hw < NIL_LINK);
                end
            end
            S_HIT:   r_ok <= (t_kind'(r_kind) != K_INSERT);
            S_ALLOC: r_ok <= 1'b1;
            default: ;
        endcase
        if (out_load) begin
            r_out.ok        <= r_ok;
            r_out.pool_full <= r_full;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bcount    <= CNT_W'(MAX_BUCKETS);
            r_head_v    <= '0;
            r_free      <= NIL_LINK;
            r_hw        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bcount <= i_cfg_data;
            end
            if (head_we) begin
                r_head_v[r_bucket] <= 1'b1;
            end
            if (r_state == S_MISS && t_kind'(r_kind) == K_INSERT
                && r_free == NIL_LINK && r_hw < NIL_LINK) begin
                r_hw <= r_hw + 1'b1;
            end
            if (r_state == S_ALLOC) begin
                r_free <= r_link_q;
            end
            if (r_state == S_FREE) begin
                r_free <= r_cur;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_hw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw <= NIL_LINK)
        else $error("high water beyond pool");
    a_free_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free == NIL_LINK) || (r_free < r_hw))
        else $error("free list head never allocated");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("second word taken while busy");
    a_full_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_full) |-> (t_kind'(r_kind) == K_INSERT && !r_ok))
        else $error("pool full flagged on bad item");

endmodule

// File: dv/chained_hash_set_tb.sv
`timescale 1ns / 100ps

module chained_hash_set_tb;
    import chs_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_word         i_in_data;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_word        o_out_data;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data;

    chained_hash_set dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow of the set state
    logic [CNT_W-1:0]    shadow_cnt;
    logic [LINK_W-1:0]   shadow_heads [MAX_BUCKETS];
    logic [KEY_BITS-1:0] shadow_keys  [POOL_NODES];
    logic [LINK_W-1:0]   shadow_links [POOL_NODES];
    logic [LINK_W-1:0]   shadow_free;
    int unsigned         shadow_used;

    t_out_word   expected_words [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    logic [31:0] recent_keys [16];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic void clear_shadow();
        shadow_cnt = CNT_W'(MAX_BUCKETS);
        foreach (shadow_heads[i]) shadow_heads[i] = NIL_LINK;
        shadow_free = NIL_LINK;
        shadow_used = 0;
    endfunction

    // find key in a chain; returns node or NIL_LINK, and its predecessor
    function automatic logic [LINK_W-1:0] chain_find(input int bkt, input logic [31:0] k,
                                                     output logic [LINK_W-1:0] pred);
        logic [LINK_W-1:0] cur;
        int steps;
        cur = shadow_heads[bkt];
        pred = NIL_LINK;
        steps = 0;
        while (cur < NIL_LINK && steps < POOL_NODES) begin
            if (shadow_keys[cur] == k) return cur;
            pred = cur;
            cur = shadow_links[cur];
            steps++;
        end
        pred = NIL_LINK;
        return NIL_LINK;
    endfunction

    function automatic t_out_word apply_op(input t_in_word w);
        t_out_word r;
        int unsigned nb;
        int bkt;
        logic [LINK_W-1:0] hit, pred, n;
        r = '0;
        nb = (shadow_cnt == 0) ? 1 : (shadow_cnt > MAX_BUCKETS ? MAX_BUCKETS : shadow_cnt);
        bkt = w.key % nb;
        hit = chain_find(bkt, w.key, pred);
        case (t_kind'(w.kind))
            K_LOOKUP: r.ok = (hit < NIL_LINK);
            K_INSERT: if (hit == NIL_LINK) begin
                n = NIL_LINK;
                if (shadow_free < NIL_LINK) begin
                    n = shadow_free;
                    shadow_free = shadow_links[n];
                end else if (shadow_used < POOL_NODES) begin
                    n = LINK_W'(shadow_used);
                    shadow_used++;
                end
                if (n < NIL_LINK) begin
                    shadow_keys[n] = w.key;
                    shadow_links[n] = shadow_heads[bkt];
                    shadow_heads[bkt] = n;
                    r.ok = 1'b1;
                end else begin
                    r.pool_full = 1'b1;
                end
            end
            K_REMOVE: if (hit < NIL_LINK) begin
                if (pred < NIL_LINK) shadow_links[pred] = shadow_links[hit];
                else shadow_heads[bkt] = shadow_links[hit];
                shadow_links[hit] = shadow_free;
                shadow_free = hit;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // send one word; prediction made at acceptance; valid stays up for a
    // back-to-back word and drops only while idling or draining
    task automatic send_word(input t_kind kd, input logic [31:0] k);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{kind: kd, key: k};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_words.push_back(apply_op('{kind: kd, key: k}));
        recent_keys[$urandom_range(15)] = k;
        @(negedge i_clk);
    endtask

    task automatic drain_and_wait();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_bucket_count(input logic [CNT_W-1:0] v);
        drain_and_wait();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_cnt = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver stall generator
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                t_out_word e;
                e = expected_words.pop_front();
                if (o_out_data.ok !== e.ok)
                    report_mismatch("ok", o_out_data.ok, e.ok);
                if (o_out_data.pool_full !== e.pool_full)
                    report_mismatch("pool_full", o_out_data.pool_full, e.pool_full);
            end
        end
    end

    task automatic test_directed();
        send_word(K_LOOKUP, 32'd0);
        send_word(K_INSERT, 32'd0);
        send_word(K_INSERT, 32'd0);
        send_word(K_LOOKUP, 32'd0);
        send_word(K_INSERT, 32'hFFFF_FFFF);
        send_word(K_INSERT, 32'h0000_0100);
        send_word(K_INSERT, 32'h0000_0200);
        send_word(K_REMOVE, 32'h0000_0100);
        send_word(K_LOOKUP, 32'h0000_0200);
        send_word(K_REMOVE, 32'h0000_0100);
        send_word(K_NONE, 32'd0);
        send_word(K_INSERT, 32'h5555_5555);
        send_word(K_INSERT, 32'hAAAA_AAAA);
        send_word(K_REMOVE, 32'hFFFF_FFFF);
        send_word(K_LOOKUP, 32'hFFFF_FFFF);
        send_word(K_REMOVE, 32'h0000_0200);
        send_word(K_REMOVE, 32'd0);
    endtask

    task automatic test_bucket_extremes();
        write_bucket_count(9'd0);
        send_word(K_LOOKUP, 32'h5555_5555);
        send_word(K_INSERT, 32'd7);
        send_word(K_LOOKUP, 32'd7);
        write_bucket_count(9'h1FF);
        send_word(K_LOOKUP, 32'd7);
        send_word(K_INSERT, 32'd300);
        write_bucket_count(9'd1);
        send_word(K_LOOKUP, 32'd300);
    endtask

    // mostly keys drawn from a small pool so hits and removes happen
    task automatic random_ops(input int count, input int key_span);
        t_kind kd;
        logic [31:0] k;
        for (int i = 0; i < count; i++) begin
            kd = t_kind'($urandom_range(9) < 4 ? K_INSERT :
                         ($urandom_range(1) ? K_LOOKUP : K_REMOVE));
            if ($urandom_range(19) == 0) kd = K_NONE;
            if ($urandom_range(3) == 0) k = recent_keys[$urandom_range(15)];
            else if ($urandom_range(7) == 0) k = $urandom();
            else k = $urandom_range(key_span);
            send_word(kd, k);
        end
    endtask

    task automatic test_random_phases();
        write_bucket_count(9'd13);
        send_idle_pct = 0;  recv_stall_pct = 0;  random_ops(130, 200);
        send_idle_pct = 48; recv_stall_pct = 0;  random_ops(130, 200);
        write_bucket_count(9'd256);
        send_idle_pct = 0;  recv_stall_pct = 48; random_ops(130, 600);
        write_bucket_count(9'd3);
        send_idle_pct = 22; recv_stall_pct = 22; random_ops(130, 100);
    endtask

    // long receiver hold-off while inputs keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 400;
        random_ops(20, 50);
    endtask

    // fill the whole pool, then hit the full case
    task automatic test_pool_full();
        write_bucket_count(9'd256);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < POOL_NODES + 4; i++) send_word(K_INSERT, 32'h1000_0000 + i);
        send_word(K_REMOVE, 32'h1000_0005);
        send_word(K_INSERT, 32'hDEAD_BEEF);
        send_word(K_INSERT, 32'hDEAD_BEF0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        foreach (recent_keys[i]) recent_keys[i] = '0;
        clear_shadow();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_bucket_extremes();
        test_random_phases();
        test_backpressure();
        test_pool_full();
        drain_and_wait();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/chs_pkg.sv
hw/rtl/chs_mod.sv
hw/rtl/chained_hash_set.sv
dv/chained_hash_set_tb.sv
